### design/dda_column_raycaster_assert.svh
// assertion macros shared by the raycaster rtl
`ifndef DDA_COLUMN_RAYCASTER_ASSERT_SVH
`define DDA_COLUMN_RAYCASTER_ASSERT_SVH

// same-cycle implication, checked outside reset
`define DDA_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked outside reset
`define DDA_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### design/dda_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package dda_pkg;

    localparam int SCREEN_WIDTH  = 320;
    localparam int SCREEN_HEIGHT = 200;
    localparam int TEX_SIZE      = 64;
    localparam int DIV_W         = 32;

    // ceil(2^21 / 5): column * 32768 / SCREEN_WIDTH is column * 512 / 5,
    // so the screen position is (column * CAM_RECIP) >> 12
    localparam int CAM_RECIP     = 419431;

    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_CAST  = 1'b1;

    localparam logic SIDE_X = 1'b0;
    localparam logic SIDE_Y = 1'b1;

    localparam logic [1:0] FACE_WEST  = 2'd0;
    localparam logic [1:0] FACE_EAST  = 2'd1;
    localparam logic [1:0] FACE_NORTH = 2'd2;
    localparam logic [1:0] FACE_SOUTH = 2'd3;

    localparam logic [2:0] CFG_CAMERA_X    = 3'd0;
    localparam logic [2:0] CFG_CAMERA_Y    = 3'd1;
    localparam logic [2:0] CFG_VIEW_DIR_X  = 3'd2;
    localparam logic [2:0] CFG_VIEW_DIR_Y  = 3'd3;
    localparam logic [2:0] CFG_CAM_PLANE_X = 3'd4;
    localparam logic [2:0] CFG_CAM_PLANE_Y = 3'd5;
    localparam logic [2:0] CFG_GRID_WIDTH  = 3'd6;
    localparam logic [2:0] CFG_GRID_HEIGHT = 3'd7;

    typedef struct packed {
        logic       operation;
        logic [8:0] column;
        logic [5:0] cell_x;
        logic [5:0] cell_y;
        logic       solid_bit;
    } t_in;

    typedef struct packed {
        logic [15:0]       perp_distance;
        logic              hit_side;
        logic [1:0]        wall_face;
        logic signed [7:0] hit_cell_x;
        logic signed [7:0] hit_cell_y;
        logic              wall_found;
        logic [5:0]        texture_column;
        logic [15:0]       wall_height;
    } t_out;

    typedef struct packed {
        logic             start;
        logic [DIV_W-1:0] num;
        logic [DIV_W-1:0] den;
    } t_div_req;

    typedef struct packed {
        logic             done;
        logic [DIV_W-1:0] quot;
    } t_div_rsp;

endpackage
`default_nettype wire

### design/dda_ram.sv
`timescale 1ns / 1ps
`default_nettype none
module dda_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

### design/dda_div.sv
`timescale 1ns / 1ps
`default_nettype none
module dda_div (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire dda_pkg::t_div_req i_req,
    output dda_pkg::t_div_rsp     o_rsp
);
    localparam int W  = dda_pkg::DIV_W;
    localparam int CW = $clog2(W + 1);

    logic [W-1:0]  r_quo;
    logic [W-1:0]  r_rem;
    logic [W-1:0]  r_den;
    logic [CW-1:0] r_cnt;
    logic          r_busy;
    logic          r_done;
    logic [W:0]    trial;
    logic          fits;

    // one quotient bit per cycle, restoring
    assign trial = {r_rem, r_quo[W-1]};
    assign fits  = trial >= {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= CW'(W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_quo <= i_req.num;
            r_rem <= '0;
            r_den <= i_req.den;
        end else if (r_busy) begin
            r_rem <= fits ? W'(trial - {1'b0, r_den}) : trial[W-1:0];
            r_quo <= {r_quo[W-2:0], fits};
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quot = r_quo;
endmodule
`default_nettype wire

### design/dda_column_raycaster.sv
`timescale 1ns / 1ps
`default_nettype none
// channel  dir  handshake                  payload
// in       in   i_in_valid / o_in_ready    i_in  (t_in)
// out      out  o_out_valid / i_out_ready  o_out (t_out)
// cfg      in   i_cfg_valid / o_cfg_ready  i_cfg_index, i_cfg_data
//
// after reset the map is cleared one row a cycle, all MAP_DIM rows, with no item taken
// a map write is a row read, then a row write back
// a cast runs three divisions on the shared divider plus, for each grid step, a step
// state and a check state for the map row read
// the result waits in an output register; the next item is taken meanwhile
// configuration beats are taken in every cycle
`include "dda_column_raycaster_assert.svh"
module dda_column_raycaster #(
    parameter int MAP_DIM    = 64,
    parameter int STEP_LIMIT = 64
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_in_valid,
    output logic               o_in_ready,
    input  wire dda_pkg::t_in  i_in,
    output logic               o_out_valid,
    input  wire logic          i_out_ready,
    output dda_pkg::t_out      o_out,
    input  wire logic          i_cfg_valid,
    output logic               o_cfg_ready,
    input  wire logic [2:0]    i_cfg_index,
    input  wire logic [15:0]   i_cfg_data
);
    localparam int AW = $clog2(MAP_DIM);
    localparam int NW = $clog2(STEP_LIMIT + 1);
    localparam int W  = dda_pkg::DIV_W;

    typedef enum logic [19:0] {
        S_CLEAR = 20'h00001, S_IDLE  = 20'h00002, S_WMOD  = 20'h00004,
        S_DCAM  = 20'h00008, S_MPX   = 20'h00010, S_MPY   = 20'h00020,
        S_RY    = 20'h00040, S_DDX   = 20'h00080, S_DDY   = 20'h00100,
        S_MFX   = 20'h00200, S_MFY   = 20'h00400, S_INIT  = 20'h00800,
        S_STEP  = 20'h01000, S_CHECK = 20'h02000, S_PERP  = 20'h04000,
        S_HGT   = 20'h08000, S_FRAC  = 20'h10000, S_TMUL  = 20'h20000,
        S_DHGT  = 20'h40000, S_DONE  = 20'h80000
    } t_state;

    t_state r_state, n_state;

    // configuration
    logic [13:0]        r_cam_x, r_cam_y;
    logic signed [15:0] r_dir_x, r_dir_y, r_pl_x, r_pl_y;
    logic [6:0]         r_gw, r_gh;

    // cast datapath
    logic signed [25:0] r_cam, r_rx, r_ry;
    logic [W-1:0]       r_ddx, r_ddy;
    logic [39:0]        r_sdx, r_sdy, r_perp;
    logic signed [9:0]  r_mx, r_my;
    logic               r_side, r_found;
    logic [NW-1:0]      r_n;
    logic [29:0]        r_frac;
    logic [8:0]         r_tex;
    logic [15:0]        r_height;
    logic signed [59:0] r_prod;

    // map write and clear
    logic [AW-1:0] r_clr, r_wx, r_wy;
    logic          r_wbit, r_wok;

    logic               r_out_valid;
    dda_pkg::t_out      r_out;

    dda_pkg::t_div_req  div_req;
    dda_pkg::t_div_rsp  div_rsp;

    logic               ram_we;
    logic [AW-1:0]      ram_waddr, ram_raddr;
    logic [MAP_DIM-1:0] ram_wdata, ram_rdata, row_mod;

    logic signed [33:0] mul_a;
    logic signed [25:0] mul_b;
    logic signed [59:0] mul_p;

    logic               in_acc, take_x, outside, solid, mirror, out_load;
    logic signed [9:0]  step_mx, step_my, gw, gh;
    logic [8:0]         fx_eff, fy_eff, tex_m;
    logic [39:0]        perp_raw;
    logic [15:0]        pq;
    logic [25:0]        abs_rx, abs_ry;
    logic [1:0]         face;

    dda_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    dda_ram #(.WIDTH(MAP_DIM), .DEPTH(MAP_DIM)) u_map (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign in_acc      = i_in_valid && o_in_ready;
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;
    assign out_load    = (r_state == S_DONE) && (!r_out_valid || i_out_ready);

    assign abs_rx = r_rx[25] ? 26'(-r_rx) : 26'(r_rx);
    assign abs_ry = r_ry[25] ? 26'(-r_ry) : 26'(r_ry);
    assign fx_eff = r_rx[25] ? {1'b0, r_cam_x[7:0]} : 9'd256 - {1'b0, r_cam_x[7:0]};
    assign fy_eff = r_ry[25] ? {1'b0, r_cam_y[7:0]} : 9'd256 - {1'b0, r_cam_y[7:0]};

    assign gw = ({3'b0, r_gw} > 10'(MAP_DIM)) ? 10'(MAP_DIM) : {3'b0, r_gw};
    assign gh = ({3'b0, r_gh} > 10'(MAP_DIM)) ? 10'(MAP_DIM) : {3'b0, r_gh};

    // ties step in y
    assign take_x  = r_sdx < r_sdy;
    assign step_mx = take_x ? r_mx + (r_rx[25] ? -10'sd1 : 10'sd1) : r_mx;
    assign step_my = take_x ? r_my : r_my + (r_ry[25] ? -10'sd1 : 10'sd1);

    assign outside = (r_mx < 0) || (r_mx >= gw) || (r_my < 0) || (r_my >= gh);
    assign solid   = ram_rdata[r_mx[AW-1:0]];

    assign perp_raw = r_side ? r_sdy - {8'b0, r_ddy} : r_sdx - {8'b0, r_ddx};
    assign pq       = (r_perp[39:24] != 16'd0) ? 16'hFFFF : r_perp[23:8];

    assign mirror = (r_side == dda_pkg::SIDE_X && !r_rx[25] && r_rx != 26'sd0) ||
                    (r_side == dda_pkg::SIDE_Y && r_ry[25]);
    assign tex_m  = mirror ? 9'(dda_pkg::TEX_SIZE - 1) - r_tex : r_tex;
    assign face   = (r_side == dda_pkg::SIDE_X) ?
                    (r_rx[25] ? dda_pkg::FACE_WEST : dda_pkg::FACE_EAST) :
                    (r_ry[25] ? dda_pkg::FACE_NORTH : dda_pkg::FACE_SOUTH);

    always_comb begin
        row_mod        = ram_rdata;
        row_mod[r_wx]  = r_wbit;
        ram_we    = 1'b0;
        ram_waddr = r_wy;
        ram_wdata = row_mod;
        ram_raddr = step_my[AW-1:0];
        case (r_state)
            S_CLEAR: begin
                ram_we    = 1'b1;
                ram_waddr = r_clr;
                ram_wdata = '0;
            end
            S_IDLE:  ram_raddr = AW'(i_in.cell_y);
            S_WMOD:  ram_we    = r_wok;
            default: ;
        endcase
    end

    // shared multiplier operands
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (r_state)
            // screen position by reciprocal of the screen width
            S_IDLE: begin
                mul_a = {25'b0, i_in.column};
                mul_b = 26'(dda_pkg::CAM_RECIP);
            end
            S_MPX: begin
                mul_a = 34'(r_pl_x);
                mul_b = r_cam;
            end
            S_MPY: begin
                mul_a = 34'(r_pl_y);
                mul_b = r_cam;
            end
            S_MFX: begin
                mul_a = {2'b0, r_ddx};
                mul_b = {17'b0, fx_eff};
            end
            S_MFY: begin
                mul_a = {2'b0, r_ddy};
                mul_b = {17'b0, fy_eff};
            end
            S_HGT: begin
                mul_a = {4'b0, r_perp[29:0]};
                mul_b = r_side ? r_rx : r_ry;
            end
            S_TMUL, S_DHGT: begin
                mul_a = {4'b0, r_frac};
                mul_b = 26'(dda_pkg::TEX_SIZE);
            end
            default: ;
        endcase
    end
    assign mul_p = mul_a * mul_b;

    always_comb begin
        div_req = '0;
        case (r_state)
            S_RY: begin
                div_req.start = 1'b1;
                div_req.num   = W'(32'h4000_0000);
                div_req.den   = {6'b0, abs_rx};
            end
            S_DDX: begin
                div_req.start = div_rsp.done;
                div_req.num   = W'(32'h4000_0000);
                div_req.den   = {6'b0, abs_ry};
            end
            S_HGT: begin
                div_req.start = 1'b1;
                div_req.num   = W'(dda_pkg::SCREEN_HEIGHT * 256);
                div_req.den   = {16'b0, pq};
            end
            default: ;
        endcase
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_CLEAR: if (r_clr == AW'(MAP_DIM - 1)) n_state = S_IDLE;
            S_IDLE: begin
                if (in_acc) begin
                    n_state = (i_in.operation == dda_pkg::OP_CAST) ? S_DCAM : S_WMOD;
                end
            end
            S_WMOD:  n_state = S_IDLE;
            S_DCAM:  n_state = S_MPX;
            S_MPX:   n_state = S_MPY;
            S_MPY:   n_state = S_RY;
            S_RY:    n_state = S_DDX;
            S_DDX:   if (div_rsp.done) n_state = S_DDY;
            S_DDY:   if (div_rsp.done) n_state = S_MFX;
            S_MFX:   n_state = S_MFY;
            S_MFY:   n_state = S_INIT;
            S_INIT:  n_state = S_STEP;
            S_STEP:  n_state = S_CHECK;
            S_CHECK: begin
                if (outside || solid || r_n == NW'(STEP_LIMIT)) begin
                    n_state = S_PERP;
                end else begin
                    n_state = S_STEP;
                end
            end
            S_PERP:  n_state = S_HGT;
            S_HGT:   n_state = S_FRAC;
            S_FRAC:  n_state = S_TMUL;
            S_TMUL:  n_state = S_DHGT;
            S_DHGT:  if (div_rsp.done) n_state = S_DONE;
            S_DONE:  if (out_load) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr       <= '0;
            r_out_valid <= 1'b0;
            r_n         <= '0;
            r_cam_x     <= 14'd0;
            r_cam_y     <= 14'd0;
            r_dir_x     <= 16'sd16384;
            r_dir_y     <= 16'sd0;
            r_pl_x      <= 16'sd0;
            r_pl_y      <= 16'sd10813;
            r_gw        <= 7'd64;
            r_gh        <= 7'd64;
        end else begin
            r_state <= n_state;
            if (r_state == S_CLEAR) begin
                r_clr <= r_clr + 1'b1;
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            if (r_state == S_INIT) begin
                r_n <= '0;
            end else if (r_state == S_STEP) begin
                r_n <= r_n + 1'b1;
            end
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    dda_pkg::CFG_CAMERA_X:    r_cam_x <= i_cfg_data[13:0];
                    dda_pkg::CFG_CAMERA_Y:    r_cam_y <= i_cfg_data[13:0];
                    dda_pkg::CFG_VIEW_DIR_X:  r_dir_x <= i_cfg_data;
                    dda_pkg::CFG_VIEW_DIR_Y:  r_dir_y <= i_cfg_data;
                    dda_pkg::CFG_CAM_PLANE_X: r_pl_x  <= i_cfg_data;
                    dda_pkg::CFG_CAM_PLANE_Y: r_pl_y  <= i_cfg_data;
                    dda_pkg::CFG_GRID_WIDTH:  r_gw    <= i_cfg_data[6:0];
                    dda_pkg::CFG_GRID_HEIGHT: r_gh    <= i_cfg_data[6:0];
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod <= mul_p;
        case (r_state)
            S_IDLE: begin
                r_wx   <= AW'(i_in.cell_x);
                r_wy   <= AW'(i_in.cell_y);
                r_wbit <= i_in.solid_bit;
                r_wok  <= ({3'b0, i_in.cell_x} < 9'(MAP_DIM)) &&
                          ({3'b0, i_in.cell_y} < 9'(MAP_DIM));
                r_cam  <= $signed({1'b0, mul_p[36:12]}) - 26'sd16384;
            end
            S_MPY:  r_rx  <= 26'(r_dir_x) + $signed(r_prod[39:14]);
            S_RY:   r_ry  <= 26'(r_dir_y) + $signed(r_prod[39:14]);
            S_DDX: begin
                if (div_rsp.done) r_ddx <= (r_rx == 26'sd0) ? '1 : div_rsp.quot;
            end
            S_DDY: begin
                if (div_rsp.done) r_ddy <= (r_ry == 26'sd0) ? '1 : div_rsp.quot;
            end
            S_MFY: r_sdx <= {7'b0, r_prod[40:8]};
            S_INIT: begin
                r_sdy   <= {7'b0, r_prod[40:8]};
                r_mx    <= {4'b0, r_cam_x[13:8]};
                r_my    <= {4'b0, r_cam_y[13:8]};
                r_found <= 1'b0;
            end
            S_STEP: begin
                r_mx   <= step_mx;
                r_my   <= step_my;
                r_side <= take_x ? dda_pkg::SIDE_X : dda_pkg::SIDE_Y;
                if (take_x) begin
                    r_sdx <= r_sdx + {8'b0, r_ddx};
                end else begin
                    r_sdy <= r_sdy + {8'b0, r_ddy};
                end
            end
            S_CHECK: r_found <= outside || solid;
            S_PERP:  r_perp  <= (perp_raw < 40'd256) ? 40'd256 : perp_raw;
            // hit point fraction, only the low 30 bits matter
            S_FRAC: begin
                r_frac <= 30'({r_side ? r_cam_x[7:0] : r_cam_y[7:0], 22'b0} +
                              r_prod[29:0]);
            end
            S_DHGT: begin
                if (div_rsp.done) begin
                    r_height <= (div_rsp.quot[W-1:16] != '0) ? 16'hFFFF
                                                             : div_rsp.quot[15:0];
                    r_tex    <= r_prod[38:30];
                end
            end
            default: ;
        endcase
        if (out_load) begin
            r_out.perp_distance  <= pq;
            r_out.hit_side       <= r_side;
            r_out.wall_face      <= face;
            r_out.hit_cell_x     <= r_mx[7:0];
            r_out.hit_cell_y     <= r_my[7:0];
            r_out.wall_found     <= r_found;
            r_out.texture_column <= tex_m[5:0];
            r_out.wall_height    <= r_height;
        end
    end

    `DDA_ASSERT_NOW(a_dist_nonzero, i_clk, i_rst_n, o_out_valid,
        o_out.perp_distance != 16'd0, "perp distance below one lsb")
    `DDA_ASSERT_NOW(a_step_bound, i_clk, i_rst_n, r_state == S_STEP,
        r_n < NW'(STEP_LIMIT), "step count beyond limit")
    `DDA_ASSERT_NEXT(a_limit_inside, i_clk, i_rst_n, out_load && !r_found,
        !o_out.hit_cell_x[7] && !o_out.hit_cell_y[7], "limit result outside map")

endmodule
`default_nettype wire
